// ----- sv/bmac_pkg.sv -----
// ----------------------------------------------------------------------------
// bmac_pkg
// Shared types and constants for the battery monitor averaging coulomb core.
// ----------------------------------------------------------------------------
package bmac_pkg;

    // Field widths
    localparam int RAW_W      = 10;
    localparam int COEF_W     = 16;
    localparam int ELAPSED_W  = 16;
    localparam int AVG_W      = 27;
    localparam int CHG_W      = 64;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // Shared multiplier operand and product widths
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;

    // Default averaging window
    localparam int WINDOW_DEF = 10;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_VOLT_OFFSET    = 3'd0,
        CFG_VOLT_COEF      = 3'd1,
        CFG_CURRENT_OFFSET = 3'd2,
        CFG_CURRENT_COEF   = 3'd3
    } t_cfg_idx;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_V,
        S_MUL_C,
        S_DIV_V,
        S_DIV_C,
        S_TAKE_QC,
        S_MUL_Q,
        S_ACC
    } t_state;

    // Operand selection for the shared multiplier
    typedef enum logic [2:0] {
        MS_VSCALE,
        MS_CSCALE,
        MS_VDIV,
        MS_CDIV,
        MS_CHARGE
    } t_mul_sel;

    // Controller to datapath commands
    typedef struct packed {
        logic     load;     // capture the accepted input item
        t_mul_sel mul_sel;  // multiplier operands this cycle
        logic     take_v;   // product holds the scaled voltage
        logic     take_c;   // product holds the scaled current
        logic     take_qv;  // product holds the voltage quotient
        logic     take_qc;  // product holds the current quotient
        logic     acc;      // product holds the charge step; update and publish
    } t_dp_cmd;

endpackage

// ----- sv/bmac_ctrl.sv -----
// ----------------------------------------------------------------------------
// bmac_ctrl
// Sequencer: handshakes on both channels and steps the datapath through
// scale, average, divide and accumulate on the shared multiplier.
// ----------------------------------------------------------------------------
module bmac_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output bmac_pkg::t_dp_cmd o_cmd
);

    bmac_pkg::t_state r_state;
    bmac_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             w_out_free;

    // Output slot is free when empty or being drained this cycle
    assign w_out_free = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bmac_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = bmac_pkg::S_MUL_V;
                end
            end
            bmac_pkg::S_MUL_V:   n_state = bmac_pkg::S_MUL_C;
            bmac_pkg::S_MUL_C:   n_state = bmac_pkg::S_DIV_V;
            bmac_pkg::S_DIV_V:   n_state = bmac_pkg::S_DIV_C;
            bmac_pkg::S_DIV_C:   n_state = bmac_pkg::S_TAKE_QC;
            bmac_pkg::S_TAKE_QC: n_state = bmac_pkg::S_MUL_Q;
            bmac_pkg::S_MUL_Q:   n_state = bmac_pkg::S_ACC;
            bmac_pkg::S_ACC: begin
                if (w_out_free) begin
                    n_state = bmac_pkg::S_IDLE;
                end
            end
            default:             n_state = bmac_pkg::S_IDLE;
        endcase
    end

    // Outputs and datapath commands
    always_comb begin
        o_cmd         = '0;
        o_cmd.mul_sel = bmac_pkg::MS_VSCALE;
        o_in_ready    = 1'b0;
        unique case (r_state)
            bmac_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            bmac_pkg::S_MUL_V: begin
                o_cmd.mul_sel = bmac_pkg::MS_VSCALE;
            end
            bmac_pkg::S_MUL_C: begin
                o_cmd.mul_sel = bmac_pkg::MS_CSCALE;
                o_cmd.take_v  = 1'b1;
            end
            bmac_pkg::S_DIV_V: begin
                o_cmd.mul_sel = bmac_pkg::MS_VDIV;
                o_cmd.take_c  = 1'b1;
            end
            bmac_pkg::S_DIV_C: begin
                o_cmd.mul_sel = bmac_pkg::MS_CDIV;
                o_cmd.take_qv = 1'b1;
            end
            bmac_pkg::S_TAKE_QC: begin
                o_cmd.take_qc = 1'b1;
            end
            bmac_pkg::S_MUL_Q: begin
                o_cmd.mul_sel = bmac_pkg::MS_CHARGE;
            end
            bmac_pkg::S_ACC: begin
                // keep the charge step in the product register while stalled
                o_cmd.mul_sel = bmac_pkg::MS_CHARGE;
                o_cmd.acc     = w_out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // Result valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.acc) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bmac_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef ASSERT_OFF
    // An accepted item always starts with the voltage scaling step
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == bmac_pkg::S_MUL_V))
        else $error("accepted item did not start the sequence");

    // A blocked result slot holds the sequencer in the accumulate step
    a_acc_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bmac_pkg::S_ACC && r_out_valid && !i_out_ready)
        |=> (r_state == bmac_pkg::S_ACC))
        else $error("accumulate step overran a pending result");

    // A new result appears only right after the accumulate step
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == bmac_pkg::S_ACC))
        else $error("result valid rose outside the accumulate step");

    // No new item is taken while one is in progress
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != bmac_pkg::S_IDLE) |-> !o_cmd.load)
        else $error("item loaded during processing");
`endif

endmodule

// ----- sv/bmac_datapath.sv -----
// ----------------------------------------------------------------------------
// bmac_datapath
// Configuration registers, one shared signed multiplier with a registered
// product, running-sum moving averages, reciprocal division by the window
// and the saturating charge accumulator.
// ----------------------------------------------------------------------------
module bmac_datapath #(
    parameter int WINDOW = bmac_pkg::WINDOW_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic        [bmac_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic        [bmac_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  bmac_pkg::t_dp_cmd                      i_cmd,
    input  logic        [bmac_pkg::RAW_W-1:0]      i_volt_raw,
    input  logic        [bmac_pkg::RAW_W-1:0]      i_current_raw,
    input  logic        [bmac_pkg::ELAPSED_W-1:0]  i_elapsed_ms,
    output logic signed [bmac_pkg::AVG_W-1:0]      o_volt_avg,
    output logic signed [bmac_pkg::AVG_W-1:0]      o_current_avg,
    output logic signed [bmac_pkg::CHG_W-1:0]      o_charge_total
);

    localparam int AVG_W  = bmac_pkg::AVG_W;
    localparam int MUL_W  = bmac_pkg::MUL_W;
    localparam int PROD_W = bmac_pkg::PROD_W;
    localparam int CHG_W  = bmac_pkg::CHG_W;
    localparam int RAW_W  = bmac_pkg::RAW_W;
    localparam int COEF_W = bmac_pkg::COEF_W;
    localparam int ELAP_W = bmac_pkg::ELAPSED_W;
    localparam int DIFF_W = RAW_W + 1;
    localparam int HIST_N = WINDOW - 1;
    localparam int LOG_W  = $clog2(WINDOW);
    // Window sum, signed; its magnitude stays below 2**MAG_W
    localparam int SUM_W  = AVG_W + LOG_W;
    localparam int MAG_W  = SUM_W - 1;
    // Exact floor(n / WINDOW) = (n * RECIP) >> SHIFT for n < 2**MAG_W
    localparam int SHIFT  = MAG_W + LOG_W;
    localparam logic [63:0] RECIP =
        ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);

    localparam logic signed [CHG_W-1:0] CHG_MAX = {1'b0, {(CHG_W-1){1'b1}}};
    localparam logic signed [CHG_W-1:0] CHG_MIN = {1'b1, {(CHG_W-1){1'b0}}};

    // Configuration
    logic [RAW_W-1:0]  r_volt_off;
    logic [COEF_W-1:0] r_volt_coef;
    logic [RAW_W-1:0]  r_cur_off;
    logic [COEF_W-1:0] r_cur_coef;

    // Captured item
    logic [RAW_W-1:0]  r_volt_raw;
    logic [RAW_W-1:0]  r_cur_raw;
    logic [ELAP_W-1:0] r_elapsed;

    // Shared multiplier
    logic signed [MUL_W-1:0]  w_mul_a;
    logic signed [MUL_W-1:0]  w_mul_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] r_prod;

    // Averaging state: history shift lines and running sums of their entries
    logic signed [AVG_W-1:0] r_vhist [HIST_N];
    logic signed [AVG_W-1:0] r_chist [HIST_N];
    logic signed [SUM_W-1:0] r_vsum;
    logic signed [SUM_W-1:0] r_csum;
    logic signed [SUM_W-1:0] r_vtot;
    logic signed [SUM_W-1:0] r_ctot;
    logic signed [AVG_W-1:0] r_vavg;
    logic signed [AVG_W-1:0] r_cavg;

    // Charge accumulator and result registers
    logic signed [CHG_W-1:0] r_charge;
    logic signed [CHG_W-1:0] w_charge_sat;
    logic signed [CHG_W:0]   w_charge_ext;
    logic signed [AVG_W-1:0] r_out_vavg;
    logic signed [AVG_W-1:0] r_out_cavg;
    logic signed [CHG_W-1:0] r_out_cap;

    logic signed [DIFF_W-1:0] w_vdiff;
    logic signed [DIFF_W-1:0] w_cdiff;
    logic signed [SUM_W-1:0]  w_vabs;
    logic signed [SUM_W-1:0]  w_cabs;
    logic signed [AVG_W-1:0]  w_fresh;
    logic        [AVG_W-1:0]  w_quot;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volt_off  <= '0;
            r_volt_coef <= '0;
            r_cur_off   <= '0;
            r_cur_coef  <= '0;
        end else if (i_cfg_we) begin
            unique case (bmac_pkg::t_cfg_idx'(i_cfg_addr))
                bmac_pkg::CFG_VOLT_OFFSET:    r_volt_off  <= i_cfg_data[RAW_W-1:0];
                bmac_pkg::CFG_VOLT_COEF:      r_volt_coef <= i_cfg_data[COEF_W-1:0];
                bmac_pkg::CFG_CURRENT_OFFSET: r_cur_off   <= i_cfg_data[RAW_W-1:0];
                bmac_pkg::CFG_CURRENT_COEF:   r_cur_coef  <= i_cfg_data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // Item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_volt_raw <= i_volt_raw;
            r_cur_raw  <= i_current_raw;
            r_elapsed  <= i_elapsed_ms;
        end
    end

    // Offset removal and window-sum magnitudes
    assign w_vdiff = $signed({1'b0, r_volt_raw}) - $signed({1'b0, r_volt_off});
    assign w_cdiff = $signed({1'b0, r_cur_raw}) - $signed({1'b0, r_cur_off});
    assign w_vabs  = r_vtot[SUM_W-1] ? -r_vtot : r_vtot;
    assign w_cabs  = r_ctot[SUM_W-1] ? -r_ctot : r_ctot;

    // Multiplier operand selection
    always_comb begin
        unique case (i_cmd.mul_sel)
            bmac_pkg::MS_VSCALE: begin
                w_mul_a = MUL_W'(w_vdiff);
                w_mul_b = $signed(MUL_W'(r_volt_coef));
            end
            bmac_pkg::MS_CSCALE: begin
                w_mul_a = MUL_W'(w_cdiff);
                w_mul_b = $signed(MUL_W'(r_cur_coef));
            end
            bmac_pkg::MS_VDIV: begin
                w_mul_a = $signed(MUL_W'(w_vabs[MAG_W-1:0]));
                w_mul_b = $signed(RECIP[MUL_W-1:0]);
            end
            bmac_pkg::MS_CDIV: begin
                w_mul_a = $signed(MUL_W'(w_cabs[MAG_W-1:0]));
                w_mul_b = $signed(RECIP[MUL_W-1:0]);
            end
            bmac_pkg::MS_CHARGE: begin
                w_mul_a = MUL_W'(r_cavg);
                w_mul_b = $signed(MUL_W'(r_elapsed));
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
    end

    // Scaled sample and truncated quotient views of the product
    assign w_fresh = r_prod[AVG_W-1:0];
    assign w_quot  = r_prod[SHIFT +: AVG_W];

    // Moving sums: total includes the fresh value, the running sum drops
    // the oldest entry as the line shifts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vsum <= '0;
            r_csum <= '0;
            for (int i = 0; i < HIST_N; i++) begin
                r_vhist[i] <= '0;
                r_chist[i] <= '0;
            end
        end else begin
            if (i_cmd.take_v) begin
                r_vsum <= r_vsum + SUM_W'(w_fresh) - SUM_W'(r_vhist[0]);
                for (int i = 0; i < HIST_N - 1; i++) begin
                    r_vhist[i] <= r_vhist[i+1];
                end
                r_vhist[HIST_N-1] <= w_fresh;
            end
            if (i_cmd.take_c) begin
                r_csum <= r_csum + SUM_W'(w_fresh) - SUM_W'(r_chist[0]);
                for (int i = 0; i < HIST_N - 1; i++) begin
                    r_chist[i] <= r_chist[i+1];
                end
                r_chist[HIST_N-1] <= w_fresh;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_v) begin
            r_vtot <= r_vsum + SUM_W'(w_fresh);
        end
        if (i_cmd.take_c) begin
            r_ctot <= r_csum + SUM_W'(w_fresh);
        end
    end

    // Quotient sign restore: division truncates toward zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_qv) begin
            r_vavg <= r_vtot[SUM_W-1] ? -$signed(w_quot) : $signed(w_quot);
        end
        if (i_cmd.take_qc) begin
            r_cavg <= r_ctot[SUM_W-1] ? -$signed(w_quot) : $signed(w_quot);
        end
    end

    // Saturating charge add
    assign w_charge_ext = {r_charge[CHG_W-1], r_charge} + {r_prod[PROD_W-1], r_prod};
    assign w_charge_sat = (w_charge_ext[CHG_W] != w_charge_ext[CHG_W-1])
                        ? (w_charge_ext[CHG_W] ? CHG_MIN : CHG_MAX)
                        : w_charge_ext[CHG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_charge <= '0;
        end else if (i_cmd.acc) begin
            r_charge <= w_charge_sat;
        end
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            r_out_vavg <= r_vavg;
            r_out_cavg <= r_cavg;
            r_out_cap  <= w_charge_sat;
        end
    end

    assign o_volt_avg     = r_out_vavg;
    assign o_current_avg  = r_out_cavg;
    assign o_charge_total = r_out_cap;

endmodule

// ----- sv/battery_monitor_average_coulomb_core.sv -----
// ----------------------------------------------------------------------------
// battery_monitor_average_coulomb_core
// Scales voltage and current samples, averages each over a sliding window
// and integrates the mean current over elapsed time into a saturating
// charge counter.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         i_in_valid / o_in_ready    volt_raw, current_raw,
//                                                   elapsed_ms
//   result    out        o_out_valid / i_out_ready  volt_avg, current_avg,
//                                                   charge_total
//   config    in         i_cfg_we (no wait)         i_cfg_addr, i_cfg_data
//
// An item passes from acceptance to its result through the single shared
// multiplier, which performs five registered products per item in turn.
// One item is in work at a time; the next is accepted once the result is
// in the output register. A result that is not taken holds the block in
// its accumulate step until the output register frees. Synchronous
// active-low reset clears the configuration, histories and charge counter;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module battery_monitor_average_coulomb_core #(
    parameter int WINDOW = bmac_pkg::WINDOW_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic        [bmac_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic        [bmac_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic        [bmac_pkg::RAW_W-1:0]      i_volt_raw,
    input  logic        [bmac_pkg::RAW_W-1:0]      i_current_raw,
    input  logic        [bmac_pkg::ELAPSED_W-1:0]  i_elapsed_ms,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [bmac_pkg::AVG_W-1:0]      o_volt_avg,
    output logic signed [bmac_pkg::AVG_W-1:0]      o_current_avg,
    output logic signed [bmac_pkg::CHG_W-1:0]      o_charge_total
);

    bmac_pkg::t_dp_cmd w_cmd;

    // Sequencer
    bmac_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    // Arithmetic and state
    bmac_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (w_cmd),
        .i_volt_raw     (i_volt_raw),
        .i_current_raw  (i_current_raw),
        .i_elapsed_ms   (i_elapsed_ms),
        .o_volt_avg     (o_volt_avg),
        .o_current_avg  (o_current_avg),
        .o_charge_total (o_charge_total)
    );

endmodule
